// ===== rtl/pbi_pkg.sv =====
`timescale 1ns / 1ps

package pbi_pkg;

	localparam int CW    = 32;
	localparam int DW    = CW + 1;
	localparam int UW    = CW + 2;
	localparam int LW    = 2 * CW + 4;
	localparam int DIG   = 11;
	localparam int NDIG  = (DW + DIG - 1) / DIG;
	localparam int SW    = NDIG * DIG;
	localparam int AW    = LW + SW;
	localparam int CNT_W = $clog2(NDIG);
	localparam int IDX_W = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_BOX_MIN_X,
		REG_BOX_MAX_X,
		REG_BOX_MIN_Y,
		REG_BOX_MAX_Y,
		REG_TOLERANCE
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_TOL,
		ST_MUL,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_UXDX,
		OP_N2,
		OP_DXDX,
		OP_D2,
		OP_QX,
		OP_XHI,
		OP_XLO,
		OP_QY,
		OP_YHI,
		OP_YLO
	} op_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mac_stat_t;

endpackage

// ===== rtl/pbi_if.sv =====
`timescale 1ns / 1ps

interface pbi_in_if;
	logic                         valid;
	logic                         ready;
	logic signed [pbi_pkg::CW-1:0] vertex_x;
	logic signed [pbi_pkg::CW-1:0] vertex_y;
	logic                         part_start;
	logic                         shape_end;

	modport source (output valid, vertex_x, vertex_y, part_start, shape_end, input ready);
	modport sink   (input valid, vertex_x, vertex_y, part_start, shape_end, output ready);
endinterface

interface pbi_out_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (output valid, hit, input ready);
	modport sink   (input valid, hit, output ready);
endinterface

// ===== rtl/pbi_mac.sv =====
`timescale 1ns / 1ps

module pbi_mac (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [pbi_pkg::LW-1:0] l,
	input  logic signed [pbi_pkg::SW-1:0] s,
	input  logic signed [pbi_pkg::AW-1:0] addend,
	output pbi_pkg::mac_stat_t            stat,
	output logic signed [pbi_pkg::AW-1:0] res
);
	import pbi_pkg::*;

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic signed [AW-1:0]  acc_q;

	logic [DIG-1:0]        digs [NDIG];
	logic [DIG-1:0]        chunk;
	logic                  first;
	logic                  last;
	logic signed [DIG:0]   dig;
	logic signed [LW+DIG:0] pp;
	logic signed [AW-1:0]  pp_ext;
	logic signed [AW-1:0]  acc_next;

	always_comb begin
		for (int k = 0; k < NDIG; k++) begin
			digs[k] = s[k*DIG +: DIG];
		end
	end

	// horner over digits, top digit signed
	always_comb begin
		chunk    = digs[cnt_q];
		first    = (cnt_q == CNT_W'(NDIG - 1));
		last     = (cnt_q == '0);
		dig      = first ? {chunk[DIG-1], chunk} : {1'b0, chunk};
		pp       = l * dig;
		pp_ext   = AW'(pp);
		acc_next = (first ? '0 : (acc_q <<< DIG)) + pp_ext + (last ? addend : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NDIG - 1);
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			acc_q <= acc_next;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign res       = acc_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiply restarted while busy");

	a_done_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && last && !start) |=> (done_q && !busy_q))
		else $error("last digit did not finish the product");

endmodule

// ===== rtl/polyline_box_intersect_core.sv =====
`timescale 1ns / 1ps
// channel  dir  payload                                    transfer
// vtx      in   vertex_x, vertex_y, part_start, shape_end  valid & ready
// res      out  hit (only after a shape_end vertex)        valid & ready
// cfg      in   cfg_idx, cfg_data                          cfg_we
//
// a vertex with no segment goes from idle straight to done; a segment that ends in a quick test
// passes through prep and tol first; a segment that needs the foot test runs up to 10 products on
// one shared 68x12 multiply-accumulate unit, each product worked digit by digit
// reset clears all control state and the box registers, no clearing pass
// res holds its result until taken; a shape_end vertex waits in the final state
// only while an older result is still pending

module polyline_box_intersect_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pbi_pkg::IDX_W-1:0]     cfg_idx,
	input  logic [pbi_pkg::CW-1:0]        cfg_data,
	pbi_in_if.sink                        vtx,
	pbi_out_if.source                     res
);
	import pbi_pkg::*;

	state_t state_q, state_d;
	op_t    op_q;

	logic signed [CW-1:0] lox_q, hix_q, loy_q, hiy_q;
	logic [CW-2:0]        tol_q;

	logic signed [CW-1:0] prev_x_q, prev_y_q;
	logic                 prev_valid_q;
	logic                 hit_flag_q;

	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q;
	logic                 shape_end_q;

	logic signed [DW-1:0] dx_q, dy_q, exh_q, exl_q, eyh_q, eyl_q;
	logic signed [UW-1:0] ux_q, uy_q;
	logic                 inside_q, away_q;

	logic signed [LW-1:0] n2_q, d2_q;
	logic signed [AW-1:0] t_q;
	logic                 seg_hit_q;
	logic                 mul_first_q;

	logic                 out_valid_q, out_hit_q;

	logic                 accept, go, out_free, tol_hit, test_fail, res_le0, res_ge0;
	logic                 mac_start;
	mac_stat_t            mac_stat;
	logic signed [LW-1:0] mac_l;
	logic signed [SW-1:0] mac_s;
	logic signed [AW-1:0] mac_add, mac_res;
	logic signed [DW-1:0] tol_s;

	assign accept   = vtx.valid && vtx.ready;
	assign go       = prev_valid_q && !vtx.part_start && !hit_flag_q;
	assign out_free = !out_valid_q || res.ready;

	assign tol_s   = $signed({2'b00, tol_q});
	assign tol_hit = (dy_q <= tol_s && dy_q >= -tol_s) || (dx_q <= tol_s && dx_q >= -tol_s);

	assign res_le0   = mac_res[AW-1] || (mac_res == '0);
	assign res_ge0   = !mac_res[AW-1];
	assign test_fail = mac_stat.done &&
		(((op_q == OP_XHI || op_q == OP_YHI) && !res_le0) ||
		 ((op_q == OP_XLO || op_q == OP_YLO) && !res_ge0));

	// operand select per step
	always_comb begin
		mac_l   = LW'(dx_q);
		mac_s   = SW'(dx_q);
		mac_add = '0;
		case (op_q)
			OP_UXDX: begin
				mac_l = LW'(ux_q);
				mac_s = SW'(dx_q);
			end
			OP_N2: begin
				mac_l   = LW'(uy_q);
				mac_s   = SW'(dy_q);
				mac_add = t_q;
			end
			OP_DXDX: begin
				mac_l = LW'(dx_q);
				mac_s = SW'(dx_q);
			end
			OP_D2: begin
				mac_l   = LW'(dy_q);
				mac_s   = SW'(dy_q);
				mac_add = t_q;
			end
			OP_QX: begin
				mac_l = n2_q;
				mac_s = SW'(dx_q);
			end
			OP_XHI: begin
				mac_l   = d2_q;
				mac_s   = SW'(exh_q);
				mac_add = t_q;
			end
			OP_XLO: begin
				mac_l   = d2_q;
				mac_s   = SW'(exl_q);
				mac_add = t_q;
			end
			OP_QY: begin
				mac_l = n2_q;
				mac_s = SW'(dy_q);
			end
			OP_YHI: begin
				mac_l   = d2_q;
				mac_s   = SW'(eyh_q);
				mac_add = t_q;
			end
			OP_YLO: begin
				mac_l   = d2_q;
				mac_s   = SW'(eyl_q);
				mac_add = t_q;
			end
			default: begin
				mac_l   = LW'(dx_q);
				mac_s   = SW'(dx_q);
				mac_add = '0;
			end
		endcase
	end

	pbi_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mac_start),
		.l      (mac_l),
		.s      (mac_s),
		.addend (mac_add),
		.stat   (mac_stat),
		.res    (mac_res)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = go ? ST_PREP : ST_DONE;
			end
			ST_PREP: state_d = ST_TOL;
			ST_TOL: begin
				if (inside_q || away_q || tol_hit) state_d = ST_DONE;
				else state_d = ST_MUL;
			end
			ST_MUL: begin
				if (mac_stat.done && (test_fail || op_q == OP_YLO)) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!shape_end_q || out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		vtx.ready = 1'b0;
		mac_start = 1'b0;
		case (state_q)
			ST_IDLE: vtx.ready = 1'b1;
			ST_MUL: begin
				mac_start = mul_first_q ||
					(mac_stat.done && !test_fail && op_q != OP_YLO);
			end
			default: begin
				vtx.ready = 1'b0;
				mac_start = 1'b0;
			end
		endcase
	end

	assign res.valid = out_valid_q;
	assign res.hit   = out_hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_UXDX;
			lox_q        <= '0;
			hix_q        <= '0;
			loy_q        <= '0;
			hiy_q        <= '0;
			tol_q        <= '0;
			prev_valid_q <= 1'b0;
			hit_flag_q   <= 1'b0;
			shape_end_q  <= 1'b0;
			seg_hit_q    <= 1'b0;
			mul_first_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_hit_q    <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_we) begin
				case (cfg_idx)
					REG_BOX_MIN_X: lox_q <= cfg_data;
					REG_BOX_MAX_X: hix_q <= cfg_data;
					REG_BOX_MIN_Y: loy_q <= cfg_data;
					REG_BOX_MAX_Y: hiy_q <= cfg_data;
					REG_TOLERANCE: tol_q <= cfg_data[CW-2:0];
					default: ;
				endcase
			end

			if (res.ready) out_valid_q <= 1'b0;

			mul_first_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						shape_end_q  <= vtx.shape_end;
						seg_hit_q    <= 1'b0;
						prev_valid_q <= !vtx.shape_end;
					end
				end
				ST_TOL: begin
					if (inside_q || (!away_q && tol_hit)) seg_hit_q <= 1'b1;
					op_q        <= OP_UXDX;
					mul_first_q <= !(inside_q || away_q || tol_hit);
				end
				ST_MUL: begin
					if (mac_stat.done) begin
						if (op_q == OP_YLO && !test_fail) seg_hit_q <= 1'b1;
						op_q <= op_t'(op_q + 1'b1);
					end
				end
				ST_DONE: begin
					if (!shape_end_q) begin
						hit_flag_q <= hit_flag_q | seg_hit_q;
					end else if (out_free) begin
						out_valid_q <= 1'b1;
						out_hit_q   <= hit_flag_q | seg_hit_q;
						hit_flag_q  <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			ax_q     <= prev_x_q;
			ay_q     <= prev_y_q;
			bx_q     <= vtx.vertex_x;
			by_q     <= vtx.vertex_y;
			prev_x_q <= vtx.vertex_x;
			prev_y_q <= vtx.vertex_y;
		end
		if (state_q == ST_PREP) begin
			dx_q     <= DW'(bx_q) - DW'(ax_q);
			dy_q     <= DW'(by_q) - DW'(ay_q);
			ux_q     <= UW'(lox_q) + UW'(hix_q) - (UW'(ax_q) <<< 1);
			uy_q     <= UW'(loy_q) + UW'(hiy_q) - (UW'(ay_q) <<< 1);
			exh_q    <= DW'(ax_q) - DW'(hix_q);
			exl_q    <= DW'(ax_q) - DW'(lox_q);
			eyh_q    <= DW'(ay_q) - DW'(hiy_q);
			eyl_q    <= DW'(ay_q) - DW'(loy_q);
			inside_q <= (ay_q <= hiy_q) && (ay_q >= loy_q) && (ax_q <= hix_q) && (ax_q >= lox_q);
			away_q   <= (ay_q > hiy_q && by_q > hiy_q) || (ay_q < loy_q && by_q < loy_q) ||
				(ax_q > hix_q && bx_q > hix_q) || (ax_q < lox_q && bx_q < lox_q);
		end
		if (state_q == ST_MUL && mac_stat.done) begin
			case (op_q)
				OP_UXDX, OP_DXDX, OP_QX, OP_QY: t_q <= mac_res;
				OP_N2: n2_q <= LW'(mac_res);
				OP_D2: d2_q <= {mac_res[LW-2:0], 1'b0};
				default: ;
			endcase
		end
	end

	a_mac_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mac_stat.done |-> (state_q == ST_MUL))
		else $error("product finished outside the multiply phase");

	a_skip_segment: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !go) |=> (state_q == ST_DONE && !seg_hit_q))
		else $error("vertex without segment did not go straight to done");

	a_inside_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TOL && inside_q) |=> (seg_hit_q && state_q == ST_DONE))
		else $error("start vertex inside box not reported");

	a_shape_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && shape_end_q && out_free) |=>
			(out_valid_q && !hit_flag_q && !prev_valid_q))
		else $error("shape end did not report and clear");

endmodule
